FILE: hw/rtl/c2rae_pkg.sv
// shared constants, types and the arctangent table for the range/azimuth/elevation core
package c2rae_pkg;

    localparam int C_IN_W            = 40;  // east, north, up
    localparam int C_ANG_W           = 32;  // binary angle, 2^32 is a full turn
    localparam int C_CW              = 64;  // cordic datapath word
    localparam int C_NORM_TOP        = 60;  // normalized magnitude lies in [2^59, 2^60)
    localparam int C_NORM_STEPS      = 6;   // shifts of 32, 16, 8, 4, 2, 1
    localparam int C_HALF_W          = C_IN_W / 2;
    localparam int C_SQ_W            = 2 * C_IN_W;
    localparam int C_RNG_ROOT_W      = C_SQ_W / 2;
    localparam int C_H_FRAC          = 20;  // fractional bits of the horizontal norm
    localparam int C_H_ROOT_W        = (C_SQ_W + 2 * C_H_FRAC) / 2;
    localparam int C_CORDIC_STAGES   = 32;

    localparam logic [C_ANG_W-1:0] C_ANG_ZERO = 32'h0000_0000;
    localparam logic [C_ANG_W-1:0] C_ANG_QTR  = 32'h4000_0000;
    localparam logic [C_ANG_W-1:0] C_ANG_HALF = 32'h8000_0000;
    localparam logic [C_ANG_W-1:0] C_ANG_3QTR = 32'hC000_0000;

    // fixed answers for axis and zero cases, carried beside the datapath
    typedef struct packed {
        logic                az_force;
        logic [C_ANG_W-1:0]  az_val;
        logic                el_force;
        logic [C_ANG_W-1:0]  el_val;
        logic                last;
    } t_fix;

    // round(atan(2^-i) / (2*pi) * 2^32), zero past the table
    function automatic logic [C_ANG_W-1:0] f_atan(input int i);
        logic [C_ANG_W-1:0] v;
        case (i)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;
            20: v = 32'h0000028C;  21: v = 32'h00000146;
            22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;
            26: v = 32'h0000000A;  27: v = 32'h00000005;
            28: v = 32'h00000003;  29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/c2rae_in_if.sv
// input channel: one east, north, up vector per transfer
interface c2rae_in_if;
    import c2rae_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [C_IN_W-1:0] east;
    logic signed [C_IN_W-1:0] north;
    logic signed [C_IN_W-1:0] up;
    logic                     last_in;

    modport source (output valid, east, north, up, last_in, input ready);
    modport sink   (input valid, east, north, up, last_in, output ready);
endinterface

FILE: hw/rtl/c2rae_out_if.sv
// output channel: range, azimuth and elevation per transfer
interface c2rae_out_if;
    import c2rae_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [C_IN_W-1:0]      range_out;
    logic [C_ANG_W-1:0]     azimuth;
    logic [C_ANG_W-1:0]     elevation;
    logic                   last_out;

    modport source (output valid, range_out, azimuth, elevation, last_out, input ready);
    modport sink   (input valid, range_out, azimuth, elevation, last_out, output ready);
endinterface

FILE: hw/rtl/c2rae_sqrt.sv
// pipelined bit-per-stage integer square root with remainder
module c2rae_sqrt import c2rae_pkg::*; #(
    parameter int RW = C_RNG_ROOT_W
) (
    input  logic            i_clk,
    input  logic            i_ce,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_rem
);

    logic [2*RW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int B = RW - 1 - g;
        logic [2*RW-1:0] w_prem;
        logic [RW-1:0]   w_proot;
        logic [2*RW:0]   w_trial;
        logic            w_take;

        if (g == 0) begin : g_first
            assign w_prem  = i_rad;
            assign w_proot = '0;
        end else begin : g_next
            assign w_prem  = r_rem[g-1];
            assign w_proot = r_root[g-1];
        end

        // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
        assign w_trial = ((2*RW+1)'(w_proot) << (B + 1)) + ((2*RW+1)'(1) << (2 * B));
        assign w_take  = {1'b0, w_prem} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (w_take) begin
                    r_rem[g]  <= w_prem - w_trial[2*RW-1:0];
                    r_root[g] <= w_proot | (RW'(1) << B);
                end else begin
                    r_rem[g]  <= w_prem;
                    r_root[g] <= w_proot;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];
    assign o_rem  = r_rem[RW-1];

endmodule

FILE: hw/rtl/c2rae_cordic.sv
// pipelined vectoring cordic: normalize, then one rotation per stage
module c2rae_cordic import c2rae_pkg::*; #(
    parameter int STAGES = C_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic signed [C_CW-1:0]   i_x,
    input  logic signed [C_CW-1:0]   i_y,
    input  logic [C_ANG_W-1:0]       i_ang,
    output logic [C_ANG_W-1:0]       o_ang
);

    function automatic logic [C_CW-1:0] f_mag(input logic signed [C_CW-1:0] v);
        return v[C_CW-1] ? C_CW'(-v) : C_CW'(v);
    endfunction

    logic signed [C_CW-1:0] r_nx [C_NORM_STEPS];
    logic signed [C_CW-1:0] r_ny [C_NORM_STEPS];
    logic [C_CW-1:0]        r_nm [C_NORM_STEPS];
    logic [C_ANG_W-1:0]     r_na [C_NORM_STEPS];

    logic signed [C_CW-1:0] r_cx [STAGES];
    logic signed [C_CW-1:0] r_cy [STAGES];
    logic [C_ANG_W-1:0]     r_ca [STAGES];

    // normalization: binary shift search, magnitude bound carried as an or of both
    for (genvar j = 0; j < C_NORM_STEPS; j++) begin : g_norm
        localparam int SH = (C_CW / 2) >> j;
        localparam int TH = C_NORM_TOP - SH;
        logic signed [C_CW-1:0] w_px, w_py;
        logic [C_CW-1:0]        w_pm;
        logic [C_ANG_W-1:0]     w_pa;

        if (j == 0) begin : g_first
            assign w_px = i_x;
            assign w_py = i_y;
            assign w_pm = f_mag(i_x) | f_mag(i_y);
            assign w_pa = i_ang;
        end else begin : g_next
            assign w_px = r_nx[j-1];
            assign w_py = r_ny[j-1];
            assign w_pm = r_nm[j-1];
            assign w_pa = r_na[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_na[j] <= w_pa;
                if (w_pm[C_CW-1:TH] == '0) begin
                    r_nx[j] <= w_px <<< SH;
                    r_ny[j] <= w_py <<< SH;
                    r_nm[j] <= w_pm << SH;
                end else begin
                    r_nx[j] <= w_px;
                    r_ny[j] <= w_py;
                    r_nm[j] <= w_pm;
                end
            end
        end
    end

    // rotation stages, direction from the sign of y
    for (genvar g = 0; g < STAGES; g++) begin : g_rot
        logic signed [C_CW-1:0] w_px, w_py;
        logic [C_ANG_W-1:0]     w_pa;

        if (g == 0) begin : g_first
            assign w_px = r_nx[C_NORM_STEPS-1];
            assign w_py = r_ny[C_NORM_STEPS-1];
            assign w_pa = r_na[C_NORM_STEPS-1];
        end else begin : g_next
            assign w_px = r_cx[g-1];
            assign w_py = r_cy[g-1];
            assign w_pa = r_ca[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!w_py[C_CW-1]) begin
                    r_cx[g] <= w_px + (w_py >>> g);
                    r_cy[g] <= w_py - (w_px >>> g);
                    r_ca[g] <= w_pa + f_atan(g);
                end else begin
                    r_cx[g] <= w_px - (w_py >>> g);
                    r_cy[g] <= w_py + (w_px >>> g);
                    r_ca[g] <= w_pa - f_atan(g);
                end
            end
        end
    end

    assign o_ang = r_ca[STAGES-1];

endmodule

FILE: hw/rtl/cartesian_to_range_az_el_core.sv
// Range, azimuth and elevation from a local east, north, up offset.
// Input channel i_in carries east, north, up (signed, 1/256 m per LSB) and a
// last flag; output channel o_out carries range (rounded Euclidean norm),
// azimuth atan2(east, north) and elevation atan2(up, horizontal norm) as
// binary angles with 2^32 a full turn, and the copied last flag.
// A vector is taken on every cycle in which valid and ready are both high;
// one result leaves per input, in order.
// The chain of squaring (3), the 60-stage horizontal-norm square root, the
// 6-step normalizer and the elevation cordic, plus input and output
// registers, makes up the pipeline.
// Throughput is one vector per cycle while the output is taken.
// The whole pipeline advances together: when the result in the output
// register is not taken, every stage holds and ready drops, so nothing is
// lost or repeated. Reset empties the pipeline (valid bits only); no other
// register is reset.
module cartesian_to_range_az_el_core import c2rae_pkg::*; #(
    parameter int CORDIC_STAGES = C_CORDIC_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    c2rae_in_if.sink            i_in,
    c2rae_out_if.source         o_out
);

    localparam int LV_RNG_SQ = 4 + C_RNG_ROOT_W;
    localparam int LV_H_SQ   = 4 + C_H_ROOT_W;
    localparam int LV_AZ     = 1 + C_NORM_STEPS + CORDIC_STAGES;
    localparam int LV_EL     = LV_H_SQ + C_NORM_STEPS + CORDIC_STAGES;
    localparam int LAT       = LV_EL + 1;
    localparam int D_AZ      = LV_EL - LV_AZ;
    localparam int D_RNG     = LV_EL - (LV_RNG_SQ + 1);
    localparam int D_FIX     = LV_EL - 1;
    localparam int D_U       = LV_H_SQ - 1;

    logic            w_adv;
    logic [LAT:1]    r_v;

    // pipeline advance and valid chain
    assign w_adv       = !r_v[LAT] || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_v[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[LAT-1:1], i_in.valid};
        end
    end

    // stage 1: input register
    logic signed [C_IN_W-1:0] r1_e, r1_n, r1_u;
    logic                     r1_last;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_e    <= i_in.east;
            r1_n    <= i_in.north;
            r1_u    <= i_in.up;
            r1_last <= i_in.last_in;
        end
    end

    // axis and zero cases
    t_fix w_fix;
    always_comb begin
        w_fix.az_force = (r1_e == '0) || (r1_n == '0);
        if (r1_e == '0) begin
            w_fix.az_val = r1_n[C_IN_W-1] ? C_ANG_HALF : C_ANG_ZERO;
        end else begin
            w_fix.az_val = r1_e[C_IN_W-1] ? C_ANG_3QTR : C_ANG_QTR;
        end
        w_fix.el_force = (r1_u == '0) || ((r1_e == '0) && (r1_n == '0));
        if (r1_u == '0) begin
            w_fix.el_val = C_ANG_ZERO;
        end else begin
            w_fix.el_val = r1_u[C_IN_W-1] ? C_ANG_3QTR : C_ANG_QTR;
        end
        w_fix.last = r1_last;
    end

    // stage 2: magnitudes and 20x20 partial products
    logic [C_IN_W-1:0] w_me, w_mn, w_mu;
    logic [C_IN_W-1:0] r2_hh [3];
    logic [C_IN_W-1:0] r2_hl [3];
    logic [C_IN_W-1:0] r2_ll [3];
    logic [C_IN_W-1:0] w_mag [3];

    assign w_me = r1_e[C_IN_W-1] ? C_IN_W'(-r1_e) : C_IN_W'(r1_e);
    assign w_mn = r1_n[C_IN_W-1] ? C_IN_W'(-r1_n) : C_IN_W'(r1_n);
    assign w_mu = r1_u[C_IN_W-1] ? C_IN_W'(-r1_u) : C_IN_W'(r1_u);
    assign w_mag[0] = w_me;
    assign w_mag[1] = w_mn;
    assign w_mag[2] = w_mu;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r2_hh[k] <= w_mag[k][C_IN_W-1:C_HALF_W] * w_mag[k][C_IN_W-1:C_HALF_W];
                r2_hl[k] <= w_mag[k][C_IN_W-1:C_HALF_W] * w_mag[k][C_HALF_W-1:0];
                r2_ll[k] <= w_mag[k][C_HALF_W-1:0] * w_mag[k][C_HALF_W-1:0];
            end
        end
    end

    // stage 3: squares
    logic [C_SQ_W-1:0] r3_sq [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r3_sq[k] <= ({r2_hh[k], C_IN_W'(0)})
                          + (C_SQ_W'(r2_hl[k]) << (C_HALF_W + 1))
                          + C_SQ_W'(r2_ll[k]);
            end
        end
    end

    // stage 4: horizontal and full sums of squares
    logic [C_SQ_W-1:0] r4_h2, r4_s;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_h2 <= r3_sq[0] + r3_sq[1];
            r4_s  <= r3_sq[0] + r3_sq[1] + r3_sq[2];
        end
    end

    // range: square root and round to nearest
    logic [C_RNG_ROOT_W-1:0] w_rng_root;
    logic [C_SQ_W-1:0]       w_rng_rem;
    logic [C_IN_W-1:0]       r_rng;

    c2rae_sqrt #(.RW(C_RNG_ROOT_W)) u_rng_sqrt (
        .i_clk  (i_clk),
        .i_ce   (w_adv),
        .i_rad  (r4_s),
        .o_root (w_rng_root),
        .o_rem  (w_rng_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rng <= (w_rng_rem > C_SQ_W'(w_rng_root)) ? C_IN_W'(w_rng_root + 1'b1)
                                                        : C_IN_W'(w_rng_root);
        end
    end

    // horizontal norm with fractional bits
    logic [C_H_ROOT_W-1:0]   w_h_root;
    logic [2*C_H_ROOT_W-1:0] w_h_rem;

    c2rae_sqrt #(.RW(C_H_ROOT_W)) u_h_sqrt (
        .i_clk  (i_clk),
        .i_ce   (w_adv),
        .i_rad  ({r4_h2, (2*C_H_FRAC)'(0)}),
        .o_root (w_h_root),
        .o_rem  (w_h_rem)
    );

    // azimuth: half-turn pre-rotation for the left half plane
    logic signed [C_CW-1:0] w_az_x, w_az_y;
    logic [C_ANG_W-1:0]     w_az_a, w_az_ang;

    always_comb begin
        if (!r1_n[C_IN_W-1]) begin
            w_az_x = C_CW'(r1_n);
            w_az_y = C_CW'(r1_e);
            w_az_a = C_ANG_ZERO;
        end else begin
            w_az_x = -C_CW'(r1_n);
            w_az_y = -C_CW'(r1_e);
            w_az_a = C_ANG_HALF;
        end
    end

    c2rae_cordic #(.STAGES(CORDIC_STAGES)) u_az_cordic (
        .i_clk (i_clk),
        .i_ce  (w_adv),
        .i_x   (w_az_x),
        .i_y   (w_az_y),
        .i_ang (w_az_a),
        .o_ang (w_az_ang)
    );

    // delay lines aligning side results with the elevation cordic
    logic signed [C_IN_W-1:0] r_u_dly   [D_U];
    logic [C_ANG_W-1:0]       r_az_dly  [D_AZ];
    logic [C_IN_W-1:0]        r_rng_dly [D_RNG];
    t_fix                     r_fix_dly [D_FIX];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u_dly[0]   <= r1_u;
            r_az_dly[0]  <= w_az_ang;
            r_rng_dly[0] <= r_rng;
            r_fix_dly[0] <= w_fix;
            for (int k = 1; k < D_U; k++)   r_u_dly[k]   <= r_u_dly[k-1];
            for (int k = 1; k < D_AZ; k++)  r_az_dly[k]  <= r_az_dly[k-1];
            for (int k = 1; k < D_RNG; k++) r_rng_dly[k] <= r_rng_dly[k-1];
            for (int k = 1; k < D_FIX; k++) r_fix_dly[k] <= r_fix_dly[k-1];
        end
    end

    // elevation: vectoring on (h, up scaled to match)
    logic signed [C_CW-1:0] w_el_x, w_el_y;
    logic [C_ANG_W-1:0]     w_el_ang;
    logic signed [C_IN_W-1:0] w_u_al;

    assign w_u_al = r_u_dly[D_U-1];
    assign w_el_x = $signed(C_CW'(w_h_root));
    assign w_el_y = $signed({{(C_CW-C_IN_W-C_H_FRAC){w_u_al[C_IN_W-1]}}, w_u_al,
                             C_H_FRAC'(0)});

    c2rae_cordic #(.STAGES(CORDIC_STAGES)) u_el_cordic (
        .i_clk (i_clk),
        .i_ce  (w_adv),
        .i_x   (w_el_x),
        .i_y   (w_el_y),
        .i_ang (C_ANG_ZERO),
        .o_ang (w_el_ang)
    );

    // output register
    t_fix                w_fix_al;
    logic [C_IN_W-1:0]   r_o_rng;
    logic [C_ANG_W-1:0]  r_o_az, r_o_el;
    logic                r_o_last;

    assign w_fix_al = r_fix_dly[D_FIX-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_rng  <= r_rng_dly[D_RNG-1];
            r_o_az   <= w_fix_al.az_force ? w_fix_al.az_val : r_az_dly[D_AZ-1];
            r_o_el   <= w_fix_al.el_force ? w_fix_al.el_val : w_el_ang;
            r_o_last <= w_fix_al.last;
        end
    end

    assign o_out.range_out = r_o_rng;
    assign o_out.azimuth   = r_o_az;
    assign o_out.elevation = r_o_el;
    assign o_out.last_out  = r_o_last;

`ifndef SYNTH
    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

    // a stall freezes every valid bit
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_v))
        else $error("valid chain moved during a stall");

    // square root remainder stays within 2*root
    a_rng_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LV_RNG_SQ] |-> (w_rng_rem <= {w_rng_root, 1'b0}))
        else $error("range root remainder out of bound");

    // horizontal root remainder stays within 2*root
    a_h_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LV_H_SQ] |-> (w_h_rem <= {w_h_root, 1'b0}))
        else $error("horizontal root remainder out of bound");
`endif

endmodule
